// ===== src/stack_with_remove_by_key_macros.svh =====
// assertion macros for the key stack
`ifndef STACK_WITH_REMOVE_BY_KEY_MACROS_SVH
`define STACK_WITH_REMOVE_BY_KEY_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge out of reset
`define SWRK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swrk assertion failed");

// next-cycle implication
`define SWRK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swrk assertion failed");

`else

`define SWRK_ASSERT_IMP(lbl, ante, cons)
`define SWRK_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== src/swrk_pkg.sv =====
package swrk_pkg;

    localparam int KEY_BITS = 32;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_LIST = 2'd2;
    localparam logic [1:0] CMD_RETR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]          command;
        logic [KEY_BITS-1:0] key_in;
    } t_cmd;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] key_out;
        logic                last;
    } t_result;

    // per-cycle move of the whole cell chain
    typedef struct packed {
        logic shift_dn;  // every cell takes the one above, top cell takes the new key
        logic shift_up;  // every cell takes the one below
        logic wrap;      // with shift_up: the tail cell takes the old top key
    } t_cell_ctl;

endpackage

// ===== src/swrk_cell.sv =====
module swrk_cell
    import swrk_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic                 i_is_tail,
    input  logic [KEY_WIDTH-1:0] i_from_up,
    input  logic [KEY_WIDTH-1:0] i_from_dn,
    input  logic [KEY_WIDTH-1:0] i_wrap_key,
    output logic [KEY_WIDTH-1:0] o_key
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.shift_dn) begin
            n_key = i_from_up;
        end else if (i_ctl.shift_up) begin
            n_key = (i_ctl.wrap && i_is_tail) ? i_wrap_key : i_from_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

// ===== src/stack_with_remove_by_key.sv =====
// lifo stack of keys with remove-by-key. the stack is a row of DEPTH cells, cell 0
// holding the top key; push shifts the row down, pop shifts it up. a command is a
// transaction taken when start is high and busy is low. each command produces one
// result (list produces one per held key, top to bottom, last set on the final one),
// shown on o_result for exactly one cycle with o_strobe high, in the cycle after the
// command or the sweep step that made it. the receiver cannot stall: results must be
// taken as they come. push and pop leave busy low and may follow back to back;
// list and retrieve keep busy high for a sweep of one step per held key, since the
// keys rotate one cell per cycle past the top cell, where the single key compare
// sits. on an empty stack every command leaves busy low. keys are KEY_WIDTH bits:
// key_in and key_out each pass on their low bits, zero-extended to fit. entries
// need no clearing after reset.
module stack_with_remove_by_key
    import swrk_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_strobe,
    output t_result o_result
);

`include "stack_with_remove_by_key_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIST,
        S_RETR
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count;   // keys held
    logic [CW-1:0]        r_left;    // sweep steps still to go
    logic [KEY_WIDTH-1:0] r_key;     // key searched for on retrieve
    logic                 r_found;
    logic                 r_strobe;
    t_result              r_result;

    logic [KEY_WIDTH-1:0] w_key [DEPTH];
    logic [DEPTH-1:0]     w_is_tail;
    logic [KEY_WIDTH-1:0] w_key_in;
    logic [KEY_BITS-1:0]  w_top_out;
    logic [KEY_BITS-1:0]  w_srch_out;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_drop;
    logic                 w_push_ok;
    logic                 w_list_end;
    t_cell_ctl            w_ctl;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    // retrieve: the first match to reach the top cell is dropped from the ring
    assign w_drop   = (r_state == S_RETR) && !r_found && (w_key[0] == r_key);
    // accepted push that has room
    assign w_push_ok  = w_accept && (i_cmd.command == CMD_PUSH) && !w_full;
    // final step of a list sweep
    assign w_list_end = (r_state == S_LIST) && (r_left == CW'(1));

    // key width against the 32-bit transaction fields
    generate
        if (KEY_WIDTH <= KEY_BITS) begin : g_narrow
            assign w_key_in   = i_cmd.key_in[KEY_WIDTH-1:0];
            assign w_top_out  = {{(KEY_BITS-KEY_WIDTH){1'b0}}, w_key[0]};
            assign w_srch_out = {{(KEY_BITS-KEY_WIDTH){1'b0}}, r_key};
        end else begin : g_wide
            assign w_key_in   = {{(KEY_WIDTH-KEY_BITS){1'b0}}, i_cmd.key_in};
            assign w_top_out  = w_key[0][KEY_BITS-1:0];
            assign w_srch_out = r_key[KEY_BITS-1:0];
        end
    endgenerate

    // chain control
    always_comb begin
        w_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (w_push_ok) begin
                    w_ctl.shift_dn = 1'b1;
                end
                if (w_accept && (i_cmd.command == CMD_POP) && !w_empty) begin
                    w_ctl.shift_up = 1'b1;
                end
            end
            S_LIST: begin
                // rotate the occupied part: top key goes to the tail
                w_ctl.shift_up = 1'b1;
                w_ctl.wrap     = 1'b1;
            end
            S_RETR: begin
                // rotate, except the matching key, which falls out
                w_ctl.shift_up = 1'b1;
                w_ctl.wrap     = !w_drop;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // row of cells
    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic [KEY_WIDTH-1:0] w_up;
            logic [KEY_WIDTH-1:0] w_dn;

            assign w_is_tail[i] = (r_count == CW'(i + 1));

            if (i == 0) begin : g_first
                assign w_up = w_key_in;
            end else begin : g_mid_up
                assign w_up = w_key[i-1];
            end

            if (i == DEPTH - 1) begin : g_end
                assign w_dn = w_key[i];
            end else begin : g_mid_dn
                assign w_dn = w_key[i+1];
            end

            swrk_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_is_tail  (w_is_tail[i]),
                .i_from_up  (w_up),
                .i_from_dn  (w_dn),
                .i_wrap_key (w_key[0]),
                .o_key      (w_key[i])
            );
        end
    endgenerate

    // state, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_found  <= 1'b0;
            r_left   <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_result.key_out <= '0;
                        r_result.last    <= 1'b1;
                        r_result.status  <= ST_OK;
                        case (i_cmd.command)
                            CMD_PUSH: begin
                                r_strobe <= 1'b1;
                                if (w_full) begin
                                    r_result.status <= ST_FULL;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            CMD_POP: begin
                                r_strobe <= 1'b1;
                                if (w_empty) begin
                                    r_result.status <= ST_EMPTY;
                                end else begin
                                    r_result.key_out <= w_top_out;
                                    r_count          <= r_count - 1'b1;
                                end
                            end
                            CMD_LIST: begin
                                if (w_empty) begin
                                    r_strobe        <= 1'b1;
                                    r_result.status <= ST_EMPTY;
                                end else begin
                                    r_left  <= r_count;
                                    r_state <= S_LIST;
                                end
                            end
                            CMD_RETR: begin
                                r_key   <= w_key_in;
                                r_found <= 1'b0;
                                if (w_empty) begin
                                    r_strobe        <= 1'b1;
                                    r_result.status <= ST_NOTFOUND;
                                end else begin
                                    r_left  <= r_count;
                                    r_state <= S_RETR;
                                end
                            end
                            default: begin
                                r_strobe <= 1'b0;
                            end
                        endcase
                    end
                end
                S_LIST: begin
                    // one listed key per cycle, straight from the top cell
                    r_strobe         <= 1'b1;
                    r_result.status  <= ST_OK;
                    r_result.key_out <= w_top_out;
                    r_result.last    <= w_list_end;
                    r_left           <= r_left - 1'b1;
                    if (w_list_end) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RETR: begin
                    if (w_drop) begin
                        r_found <= 1'b1;
                        r_count <= r_count - 1'b1;
                    end
                    r_left <= r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        // ring is back in order, report the outcome
                        r_strobe      <= 1'b1;
                        r_result.last <= 1'b1;
                        if (r_found || w_drop) begin
                            r_result.status  <= ST_OK;
                            r_result.key_out <= w_srch_out;
                        end else begin
                            r_result.status  <= ST_NOTFOUND;
                            r_result.key_out <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // the last step of a list sweep strobes the final result and frees the block
    `SWRK_ASSERT_NXT(a_list_end, w_list_end, (r_state == S_IDLE) && o_strobe && o_result.last)

    // an accepted push on a stack that is not full grows it by one
    `SWRK_ASSERT_NXT(a_push_grow, w_push_ok, r_count == CW'($past(r_count) + 1'b1))

    // a retrieve sweep removes at most one key per step, and at most one in total
    `SWRK_ASSERT_IMP(a_one_drop, w_drop, !r_found)

    // a result that is not the last of its command only comes while busy
    `SWRK_ASSERT_IMP(a_mid_busy, o_strobe && !o_result.last, busy)

    // the count never runs past the depth
    `SWRK_ASSERT_IMP(a_cnt_range, 1'b1, r_count <= CW'(DEPTH))

endmodule
